[rtl/dafe_pkg.sv]
// Package for the decimal ASCII frame encoder: constants, types, digit helper.
`default_nettype none

package dafe_pkg;

  // Widths and limits of the value path
  localparam int VALUE_W   = 16;
  localparam int MAG_W     = 14;
  localparam int CHAR_W    = 8;
  localparam int MAX_BYTES = 7;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  localparam logic signed [VALUE_W-1:0] SAT_POS = 16'sd9999;
  localparam logic signed [VALUE_W-1:0] SAT_NEG = -16'sd9999;
  localparam logic [MAG_W-1:0]          SAT_MAG = 14'd9999;

  // Character codes
  localparam logic [CHAR_W-1:0] CHR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_MINUS   = 8'h2D;
  localparam logic [CHAR_W-1:0] CHR_NEWLINE = 8'h0A;

  // Decimal weights
  localparam logic [MAG_W-1:0] W_THOUSAND = 14'd1000;
  localparam logic [MAG_W-1:0] W_HUNDRED  = 14'd100;
  localparam logic [MAG_W-1:0] W_TEN      = 14'd10;

  typedef logic [CHAR_W-1:0] char_t;

  // One formatted item: bytes in send order, byte 0 first
  typedef struct packed {
    char_t [MAX_BYTES-1:0] bytes;
    logic  [CNT_W-1:0]     len;
  } frame_t;

  typedef struct packed {
    logic [3:0]       digit;
    logic [MAG_W-1:0] rem;
  } dstep_t;

  // Pick one decimal digit by parallel compares against k * weight
  function automatic dstep_t digit_step(input logic [MAG_W-1:0] val,
                                        input logic [MAG_W-1:0] w);
    dstep_t           res;
    logic [MAG_W-1:0] thr;
    res.digit = 4'd0;
    res.rem   = val;
    for (int k = 1; k <= 9; k++) begin
      thr = w * MAG_W'(k);
      if (val >= thr) begin
        res.digit = 4'(k);
        res.rem   = val - thr;
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/dafe_fmt.sv]
// Formatter: magnitude to decimal digits, packed into the byte list of one item.
`default_nettype none

module dafe_fmt
  import dafe_pkg::*;
(
  input  wire logic [MAG_W-1:0] mag,
  input  wire logic             neg,
  input  wire char_t            ident,
  input  wire logic             last,
  output frame_t                frame
);

  dstep_t s3, s2, s1;
  char_t  cand [MAX_BYTES];
  logic   en   [MAX_BYTES];

  // Split the magnitude into thousands, hundreds, tens and ones
  always_comb begin
    s3 = digit_step(mag, W_THOUSAND);
    s2 = digit_step(s3.rem, W_HUNDRED);
    s1 = digit_step(s2.rem, W_TEN);
  end

  // Build candidate bytes with their enables; drop leading zeros
  always_comb begin
    cand[0] = ident;
    en[0]   = 1'b1;
    cand[1] = CHR_MINUS;
    en[1]   = neg;
    cand[2] = CHR_ZERO + char_t'(s3.digit);
    en[2]   = (s3.digit != 4'd0);
    cand[3] = CHR_ZERO + char_t'(s2.digit);
    en[3]   = en[2] || (s2.digit != 4'd0);
    cand[4] = CHR_ZERO + char_t'(s1.digit);
    en[4]   = en[3] || (s1.digit != 4'd0);
    cand[5] = CHR_ZERO + char_t'(s1.rem[3:0]);
    en[5]   = 1'b1;
    cand[6] = CHR_NEWLINE;
    en[6]   = last;
  end

  // Compact enabled bytes to the front
  always_comb begin
    logic [CNT_W-1:0] idx;
    idx = '0;
    frame.bytes = '0;
    for (int i = 0; i < MAX_BYTES; i++) begin
      if (en[i]) begin
        frame.bytes[idx] = cand[i];
        idx = idx + CNT_W'(1);
      end
    end
    frame.len = idx;
  end

endmodule

`default_nettype wire

[rtl/decimal_ascii_frame_encoder.sv]
// Top level: input register, formatter and output byte shifter.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  input   | start / busy       | in_value, in_ident_char, in_last_value
//  result  | out_valid (strobe) | out_char, out_last_char
//
// An item has 2 to 7 bytes (identifier, optional minus, 1 to 4 digits,
// optional newline), sent by the one-byte-per-cycle output shift register.
// With the shifter empty or on its final byte, the item passes from the input
// register into the shifter, whose first byte is then on the ports; otherwise
// the item waits in the input register, busy high, until the shifter reaches
// its final byte. A new item is taken while the previous one is still shifting out.
// Reset (rst_n low, synchronous) drops any item in flight; no clearing pass.
// The receiver cannot stall: each byte is on the ports for one cycle.
`default_nettype none

module decimal_ascii_frame_encoder
  import dafe_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [VALUE_W-1:0] in_value,
  input  wire logic        [CHAR_W-1:0]  in_ident_char,
  input  wire logic                      in_last_value,
  output logic                           out_valid,
  output logic             [CHAR_W-1:0]  out_char,
  output logic                           out_last_char
);

  logic             item_vld_r, item_vld_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  char_t            ident_r;
  logic             last_r;

  char_t [MAX_BYTES-1:0] buf_r, buf_nxt;
  logic  [CNT_W-1:0]     cnt_r, cnt_nxt;

  frame_t frame;
  logic   accept;
  logic   load;

  // Load the shifter when it is empty or sending its final byte
  assign load   = item_vld_r && (cnt_r <= CNT_W'(1));
  assign busy   = item_vld_r && !load;
  assign accept = start && !busy;

  // Saturate the incoming value to a sign and magnitude
  always_comb begin
    logic signed [VALUE_W-1:0] neg_val;
    neg_val = -in_value;
    if (in_value > SAT_POS) begin
      mag_nxt = SAT_MAG;
      neg_nxt = 1'b0;
    end else if (in_value < SAT_NEG) begin
      mag_nxt = SAT_MAG;
      neg_nxt = 1'b1;
    end else if (in_value < 0) begin
      mag_nxt = neg_val[MAG_W-1:0];
      neg_nxt = 1'b1;
    end else begin
      mag_nxt = in_value[MAG_W-1:0];
      neg_nxt = 1'b0;
    end
  end

  // Hold the accepted item until the shifter takes it
  always_comb begin
    item_vld_nxt = item_vld_r;
    if (accept) begin
      item_vld_nxt = 1'b1;
    end else if (load) begin
      item_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      ident_r <= in_ident_char;
      last_r  <= in_last_value;
    end
  end

  dafe_fmt u_fmt (
    .mag   (mag_r),
    .neg   (neg_r),
    .ident (ident_r),
    .last  (last_r),
    .frame (frame)
  );

  // Load a new item or advance one byte
  always_comb begin
    buf_nxt = buf_r;
    cnt_nxt = cnt_r;
    if (load) begin
      buf_nxt = frame.bytes;
      cnt_nxt = frame.len;
    end else if (cnt_r != '0) begin
      for (int i = 0; i < MAX_BYTES - 1; i++) begin
        buf_nxt[i] = buf_r[i+1];
      end
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

  assign out_valid     = (cnt_r != '0);
  assign out_char      = buf_r[0];
  assign out_last_char = (cnt_r == CNT_W'(1));

`ifndef NO_ASSERTIONS
  // Bytes of one item go out in consecutive cycles
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_char |=> out_valid)
    else $error("gap inside an item's byte run");

  // An accepted item is held in the input register next cycle
  a_accept_held: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> item_vld_r)
    else $error("accepted item lost");

  // A loaded item always starts a run of at least two bytes
  a_load_len: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (cnt_r >= CNT_W'(2)) && (cnt_r <= CNT_W'(MAX_BYTES)))
    else $error("bad byte count after load");
`endif

endmodule

`default_nettype wire
